>>> sv/scas_pkg.sv
// ----------------------------------------------------------------------------
// scas_pkg
// Shared constants, codes and helpers for the script call argument splitter.
// ----------------------------------------------------------------------------
package scas_pkg;

  // Default saturation point of byte offsets
  localparam longint unsigned MAX_OFFSET_DEF = 64'd65535;

  // Field widths
  localparam int ByteW  = 8;
  localparam int FieldW = 16;
  localparam int KindW  = 2;
  localparam int OutcW  = 2;
  localparam int TdataW = 2 * FieldW;
  localparam int TuserW = 1 + KindW + OutcW;

  // Characters of interest
  localparam logic [ByteW-1:0] ChParOpen  = 8'h28;
  localparam logic [ByteW-1:0] ChParClose = 8'h29;
  localparam logic [ByteW-1:0] ChBslash   = 8'h5C;
  localparam logic [ByteW-1:0] ChBrOpen   = 8'h7B;
  localparam logic [ByteW-1:0] ChBrClose  = 8'h7D;
  localparam logic [ByteW-1:0] ChDquote   = 8'h22;
  localparam logic [ByteW-1:0] ChSquote   = 8'h27;
  localparam logic [ByteW-1:0] ChComma    = 8'h2C;

  // Argument kinds
  localparam logic [KindW-1:0] KindBare   = 2'd0;
  localparam logic [KindW-1:0] KindSingle = 2'd1;
  localparam logic [KindW-1:0] KindDouble = 2'd2;
  localparam logic [KindW-1:0] KindBrace  = 2'd3;

  // Parse outcomes
  localparam logic [OutcW-1:0] OutcClosed  = 2'd0;
  localparam logic [OutcW-1:0] OutcBadChar = 2'd1;
  localparam logic [OutcW-1:0] OutcOpenEnd = 2'd2;
  localparam logic [OutcW-1:0] OutcNoParen = 2'd3;

  // Whitespace set: NUL, TAB, LF, FF, CR, space
  function automatic logic is_space(input logic [ByteW-1:0] b);
    return (b == 8'h00) || (b == 8'h09) || (b == 8'h0A) ||
           (b == 8'h0C) || (b == 8'h0D) || (b == 8'h20);
  endfunction

endpackage

>>> sv/script_call_argument_splitter_top.sv
// ----------------------------------------------------------------------------
// script_call_argument_splitter_top
// Splits the parenthesized argument list that follows a script function name.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                          | tuser                    | tlast
//  s_axis   | in  | [7:0] byte_in                  | -                        | last_byte
//  m_axis   | out | [15:0] arg_start,[31:16] length| [0] found,[2:1] kind,    | finished
//           |     |                                | [4:3] outcome            |
//
// One byte is taken per cycle; each beat is decoded in the cycle it is
// accepted and its result, if any, lands in the output register.
// The result appears in the cycle after the input beat is accepted.
// A full output register that is not taken stalls the input side.
// Reset clears the parse state and the output valid flag.
// ----------------------------------------------------------------------------
module script_call_argument_splitter_top
  import scas_pkg::*;
#(
  parameter longint unsigned MaxOffset = MAX_OFFSET_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [ByteW-1:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic              s_axis_tlast,   // last_byte
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TdataW-1:0] m_axis_tdata,   // [15:0] arg_start, [31:16] arg_length
  output logic [TuserW-1:0] m_axis_tuser,   // [0] arg_found, [2:1] arg_kind, [4:3] outcome
  output logic              m_axis_tlast    // finished
);

  localparam int PosW = $clog2(MaxOffset + 64'd1);
  localparam logic [PosW-1:0] PosMax = PosW'(MaxOffset);

  typedef enum logic [2:0] {
    PH_AWAIT  = 3'd0,
    PH_LIST   = 3'd1,
    PH_BARE   = 3'd2,
    PH_SINGLE = 3'd3,
    PH_DOUBLE = 3'd4,
    PH_BRACE  = 3'd5
  } phase_e;

  phase_e          phase_q, phase_d;
  logic            esc_q, esc_d;
  logic            done_q, done_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] start_q, start_d;

  logic              ovalid_q;
  logic [TdataW-1:0] odata_q, odata_d;
  logic [TuserW-1:0] ouser_q, ouser_d;
  logic              olast_q, olast_d;

  logic              accept;
  logic              emit;
  logic              found, fin;
  logic [KindW-1:0]  kind;
  logic [OutcW-1:0]  outc;
  logic [PosW-1:0]   diff, len;
  logic [ByteW-1:0]  b;
  logic [ByteW-1:0]  close_ch;

  assign s_axis_tready = !ovalid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign diff          = pos_q - start_q;

  // Closing character of the open quoted or brace argument
  always_comb begin
    unique case (phase_q)
      PH_SINGLE: close_ch = ChSquote;
      PH_DOUBLE: close_ch = ChDquote;
      default:   close_ch = ChBrClose;
    endcase
  end

  // Per-byte parse step
  always_comb begin
    phase_d = phase_q;
    esc_d   = esc_q;
    done_d  = done_q;
    start_d = start_q;
    pos_d   = (pos_q >= PosMax) ? PosMax : pos_q + PosW'(1);
    found   = 1'b0;
    fin     = 1'b0;
    kind    = KindBare;
    outc    = OutcClosed;
    len     = '0;

    unique case (phase_q)
      PH_AWAIT: begin
        if (b == ChParOpen) begin
          phase_d = PH_LIST;
        end else if (!is_space(b)) begin
          fin  = 1'b1;
          outc = OutcBadChar;
        end
      end
      PH_LIST: begin
        if (b == ChDquote) begin
          start_d = pos_q;
          phase_d = PH_DOUBLE;
        end else if (b == ChSquote) begin
          start_d = pos_q;
          phase_d = PH_SINGLE;
        end else if (b == ChBrOpen) begin
          start_d = pos_q;
          phase_d = PH_BRACE;
        end else if (b == ChParClose) begin
          fin = 1'b1;
        end else if (!is_space(b) && b != ChComma) begin
          start_d = pos_q;
          phase_d = PH_BARE;
        end
      end
      PH_BARE: begin
        if (is_space(b) || b == ChComma || b == ChParClose) begin
          found   = 1'b1;
          len     = diff;
          phase_d = PH_LIST;
          fin     = (b == ChParClose);
        end
      end
      PH_SINGLE, PH_DOUBLE, PH_BRACE: begin
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (b == ChBslash) begin
          esc_d = 1'b1;
        end else if (b == close_ch) begin
          found   = 1'b1;
          kind    = KindW'(phase_q - 3'd2);
          len     = (diff >= PosMax) ? PosMax : diff + PosW'(1);
          phase_d = PH_LIST;
        end
      end
      default: begin
        fin  = 1'b1;
        outc = OutcBadChar;
      end
    endcase

    // End of buffer forces an outcome
    if (!fin && s_axis_tlast) begin
      fin  = 1'b1;
      outc = (phase_d == PH_AWAIT) ? OutcNoParen : OutcOpenEnd;
    end

    if (fin) begin
      done_d = 1'b1;
    end

    // Bytes after the end only wait for the buffer to close
    if (done_q) begin
      phase_d = phase_q;
      esc_d   = esc_q;
      start_d = start_q;
      pos_d   = pos_q;
      found   = 1'b0;
      fin     = 1'b0;
    end

    // Last byte returns the parse state to reset
    if (s_axis_tlast) begin
      phase_d = PH_AWAIT;
      esc_d   = 1'b0;
      done_d  = 1'b0;
      pos_d   = '0;
      start_d = '0;
    end

    emit    = found || fin;
    odata_d = {(found ? FieldW'(len) : FieldW'(0)),
               (found ? FieldW'(start_q) : FieldW'(0))};
    ouser_d = {(fin ? outc : OutcClosed), (found ? kind : KindBare), found};
    olast_d = fin;
  end

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_AWAIT;
      esc_q   <= 1'b0;
      done_q  <= 1'b0;
      pos_q   <= '0;
      start_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      done_q  <= done_d;
      pos_q   <= pos_d;
      start_q <= start_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (s_axis_tready) begin
      ovalid_q <= accept && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      odata_q <= odata_d;
      ouser_q <= ouser_d;
      olast_q <= olast_d;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;
  assign m_axis_tlast  = olast_q;

endmodule

>>> sv/scas_checker.sv
// ----------------------------------------------------------------------------
// scas_checker
// Port-level checks for the script call argument splitter.
// ----------------------------------------------------------------------------
module scas_checker
  import scas_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [TdataW-1:0] m_axis_tdata,
  input logic [TuserW-1:0] m_axis_tuser,
  input logic              m_axis_tlast
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // Input is only held off by a stalled full output register
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // No argument means zero argument fields
  a_no_arg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0
      && m_axis_tuser[2:1] == KindBare)
    else $error("argument fields set without an argument");

  // Outcome only on a finishing beat; each beat carries something
  a_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[4:3] == OutcClosed
      && m_axis_tuser[0])
    else $error("empty beat or outcome without finish");

  // A quoted or brace argument counts its delimiters, so it is never empty;
  // a bare one can be once the offsets have saturated
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[2:1] != KindBare
      |-> m_axis_tdata[TdataW-1:FieldW] != '0)
    else $error("zero-length quoted argument reported");

endmodule

bind script_call_argument_splitter_top scas_checker u_scas_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> test/tb_script_call_argument_splitter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_script_call_argument_splitter_top
// Streams byte buffers into the argument splitter and checks every result
// beat against a cycle-free parser model kept in this bench, in order.
// ----------------------------------------------------------------------------
module tb_script_call_argument_splitter_top;
  import scas_pkg::*;

  localparam logic [FieldW-1:0] OffsetMax  = FieldW'(MAX_OFFSET_DEF);
  localparam int                CycleLimit = 2_000_000;

  // Parser phases of the model
  typedef enum logic [2:0] {
    PhAwaitOpen = 3'd0,
    PhList      = 3'd1,
    PhBare      = 3'd2,
    PhSingle    = 3'd3,
    PhDouble    = 3'd4,
    PhBrace     = 3'd5
  } parse_phase_e;

  typedef struct packed {
    logic              found;
    logic [FieldW-1:0] start;
    logic [FieldW-1:0] arg_len;
    logic [KindW-1:0]  kind;
    logic              finished;
    logic [OutcW-1:0]  outcome;
  } arg_report_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } buf_beat_t;

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic [ByteW-1:0]  in_byte  = '0;
  logic              in_last  = 1'b0;
  logic              out_ready = 1'b0;
  logic              s_axis_tready;
  logic              m_axis_tvalid;
  logic [TdataW-1:0] m_axis_tdata;
  logic [TuserW-1:0] m_axis_tuser;
  logic              m_axis_tlast;

  // Stimulus and expectation stores
  buf_beat_t   byte_feed[$];
  arg_report_t expected_reports[$];

  // Parser model state
  parse_phase_e      p_phase;
  logic              p_esc;
  logic [FieldW-1:0] p_pos;
  logic [FieldW-1:0] p_start;
  logic              p_done;

  int send_idle = 9;
  int recv_idle = 51;
  int bytes_taken;
  int hold_left;
  bit hold_done;
  int results_seen;
  int errors;
  int cycles;

  script_call_argument_splitter_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (in_byte),        // [7:0] byte_in
    .s_axis_tlast  (in_last),        // last_byte
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (m_axis_tdata),   // [15:0] arg_start, [31:16] arg_length
    .m_axis_tuser  (m_axis_tuser),   // [0] arg_found, [2:1] arg_kind, [4:3] outcome
    .m_axis_tlast  (m_axis_tlast)    // finished
  );

  // Clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model
  function automatic bit blank_byte(input logic [ByteW-1:0] b);
    return b == 8'h00 || b == 8'h09 || b == 8'h0A || b == 8'h0C ||
           b == 8'h0D || b == 8'h20;
  endfunction

  task automatic clear_parser();
    p_phase = PhAwaitOpen;
    p_esc   = 1'b0;
    p_pos   = '0;
    p_start = '0;
    p_done  = 1'b0;
  endtask

  // Advance the parser by one byte; has_report tells whether a beat is due
  task automatic parse_byte(input logic [ByteW-1:0] b, input logic lst,
                            output bit has_report, output arg_report_t rep);
    logic [FieldW-1:0] pos;
    logic [FieldW-1:0] span;
    logic [ByteW-1:0]  close_ch;
    bit                fin;
    pos        = p_pos;
    rep        = '0;
    fin        = 1'b0;
    has_report = 1'b0;
    if (p_done) begin
      // bytes after the end are dropped until the buffer closes
      if (lst) clear_parser();
      return;
    end
    case (p_phase)
      PhAwaitOpen: begin
        if (b == ChParOpen) begin
          p_phase = PhList;
        end else if (!blank_byte(b)) begin
          fin         = 1'b1;
          rep.outcome = OutcBadChar;
        end
      end
      PhList: begin
        if (b == ChDquote) begin
          p_start = pos;
          p_phase = PhDouble;
        end else if (b == ChSquote) begin
          p_start = pos;
          p_phase = PhSingle;
        end else if (b == ChBrOpen) begin
          p_start = pos;
          p_phase = PhBrace;
        end else if (b == ChParClose) begin
          fin         = 1'b1;
          rep.outcome = OutcClosed;
        end else if (!blank_byte(b) && b != ChComma) begin
          p_start = pos;
          p_phase = PhBare;
        end
      end
      PhBare: begin
        if (blank_byte(b) || b == ChComma || b == ChParClose) begin
          rep.found   = 1'b1;
          rep.kind    = KindBare;
          rep.start   = p_start;
          rep.arg_len = pos - p_start;
          p_phase     = PhList;
          if (b == ChParClose) begin
            fin         = 1'b1;
            rep.outcome = OutcClosed;
          end
        end
      end
      PhSingle, PhDouble, PhBrace: begin
        close_ch = (p_phase == PhSingle) ? ChSquote :
                   (p_phase == PhDouble) ? ChDquote : ChBrClose;
        if (p_esc) begin
          p_esc = 1'b0;
        end else if (b == ChBslash) begin
          p_esc = 1'b1;
        end else if (b == close_ch) begin
          span        = pos - p_start;
          rep.found   = 1'b1;
          rep.kind    = (p_phase == PhSingle) ? KindSingle :
                        (p_phase == PhDouble) ? KindDouble : KindBrace;
          rep.start   = p_start;
          rep.arg_len = (span == OffsetMax) ? OffsetMax : span + 1'b1;
          p_phase     = PhList;
        end
      end
      default: begin
        fin         = 1'b1;
        rep.outcome = OutcBadChar;
      end
    endcase

    p_pos = (pos == OffsetMax) ? OffsetMax : pos + 1'b1;

    // end of buffer closes whatever is still open
    if (!fin && lst) begin
      fin         = 1'b1;
      rep.outcome = (p_phase == PhAwaitOpen) ? OutcNoParen : OutcOpenEnd;
    end
    if (fin) begin
      if (lst) clear_parser();
      else     p_done = 1'b1;
    end
    rep.finished = fin;
    has_report   = rep.found || fin;
  endtask

  // ------------------------------------------------------------ stimulus
  task automatic feed_seq(input logic [ByteW-1:0] seq[$]);
    buf_beat_t beat;
    foreach (seq[i]) begin
      beat.data = seq[i];
      beat.last = (i == seq.size() - 1);
      byte_feed.push_back(beat);
    end
  endtask

  function automatic logic [ByteW-1:0] pick_blank();
    logic [ByteW-1:0] b;
    case ($urandom_range(5))
      0:       b = 8'h00;
      1:       b = 8'h09;
      2:       b = 8'h0A;
      3:       b = 8'h0C;
      4:       b = 8'h0D;
      default: b = 8'h20;
    endcase
    return b;
  endfunction

  // Bare argument byte; the first one must not open a quote or a brace
  function automatic logic [ByteW-1:0] pick_bare(input bit first);
    logic [ByteW-1:0] b;
    do begin
      b = ByteW'($urandom_range(255));
    end while (blank_byte(b) || b == ChComma || b == ChParClose ||
               (first && (b == ChSquote || b == ChDquote || b == ChBrOpen)));
    return b;
  endfunction

  // Byte biased toward the characters the parser reacts to
  function automatic logic [ByteW-1:0] pick_noise();
    logic [ByteW-1:0] b;
    case ($urandom_range(9))
      0:       b = ChParOpen;
      1:       b = ChParClose;
      2:       b = ChComma;
      3:       b = ChSquote;
      4:       b = ChDquote;
      5:       b = ChBrOpen;
      6:       b = ChBslash;
      7:       b = pick_blank();
      default: b = ByteW'($urandom_range(255));
    endcase
    return b;
  endfunction

  // One call buffer: mostly a well formed list, sometimes broken or cut short
  task automatic queue_call(output int useful);
    logic [ByteW-1:0] bq[$];
    logic [ByteW-1:0] close_ch;
    logic [ByteW-1:0] b;
    int               n_args;
    int               cut;
    repeat ($urandom_range(2)) bq.push_back(pick_blank());
    if ($urandom_range(9) == 0) bq.push_back(pick_noise());
    bq.push_back(ChParOpen);
    n_args = $urandom_range(4);
    for (int i = 0; i < n_args; i++) begin
      repeat ($urandom_range(1)) bq.push_back(pick_blank());
      case ($urandom_range(3))
        0: begin
          bq.push_back(pick_bare(1'b1));
          repeat ($urandom_range(4)) bq.push_back(pick_bare(1'b0));
        end
        default: begin
          case ($urandom_range(2))
            0:       close_ch = ChSquote;
            1:       close_ch = ChDquote;
            default: close_ch = ChBrClose;
          endcase
          bq.push_back(close_ch == ChBrClose ? ChBrOpen : close_ch);
          repeat ($urandom_range(5)) begin
            if ($urandom_range(99) < 15) begin
              // escaped byte, possibly the closing character itself
              bq.push_back(ChBslash);
              bq.push_back(ByteW'($urandom_range(255)));
            end else begin
              do b = ByteW'($urandom_range(255));
              while (b == close_ch || b == ChBslash);
              bq.push_back(b);
            end
          end
          bq.push_back(close_ch);
        end
      endcase
      case ($urandom_range(9))
        0:       ;
        1, 2, 3: bq.push_back(pick_blank());
        default: bq.push_back(ChComma);
      endcase
    end
    if ($urandom_range(99) < 85) bq.push_back(ChParClose);
    useful = bq.size();
    // bytes after the closing paren are ignored by the block
    repeat ($urandom_range(2)) bq.push_back(pick_noise());
    if ($urandom_range(4) == 0) begin
      cut = $urandom_range(bq.size(), 1);
      while (bq.size() > cut) void'(bq.pop_back());
      if (useful > cut) useful = cut;
    end
    feed_seq(bq);
  endtask

  task automatic queue_noise(output int useful);
    logic [ByteW-1:0] bq[$];
    repeat ($urandom_range(6, 1)) bq.push_back(pick_noise());
    useful = bq.size();
    feed_seq(bq);
  endtask

  task automatic queue_random(input int want);
    int fed;
    int n;
    fed = 0;
    while (fed < want) begin
      if ($urandom_range(9) < 8) queue_call(n);
      else                       queue_noise(n);
      fed += n;
    end
  endtask

  // Sender pause: hold back until every fed byte is taken and answered
  task automatic wait_drain();
    while (byte_feed.size() != 0 || in_valid || expected_reports.size() != 0)
      @(negedge clk_i);
  endtask

  // -------------------------------------------------------------- driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_p
    buf_beat_t   beat;
    arg_report_t rep;
    bit          has_report;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_byte  <= '0;
      in_last  <= 1'b0;
      bytes_taken <= 0;
    end else begin
      if (in_valid && s_axis_tready) begin
        parse_byte(in_byte, in_last, has_report, rep);
        if (has_report) expected_reports.push_back(rep);
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid || s_axis_tready) begin
        if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle) begin
          beat = byte_feed.pop_front();
          in_valid <= 1'b1;
          in_byte  <= beat.data;
          in_last  <= beat.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, once, so the block fills and stalls its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_taken >= 150) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end
  end

  // ------------------------------------------------------------- monitor
  task automatic flag_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      flag_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                              results_seen, name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_p
    arg_report_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid && out_ready) begin
        if (expected_reports.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with nothing expected",
                                  results_seen));
        end else begin
          want = expected_reports.pop_front();
          check_field("arg_found",  m_axis_tuser[0],    want.found);
          check_field("arg_start",  m_axis_tdata[15:0], want.start);
          check_field("arg_length", m_axis_tdata[31:16], want.arg_len);
          check_field("arg_kind",   m_axis_tuser[2:1],  want.kind);
          check_field("finished",   m_axis_tlast,       want.finished);
          check_field("outcome",    m_axis_tuser[4:3],  want.outcome);
        end
        results_seen++;
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------ sequence
  initial begin : main_p
    logic [ByteW-1:0] seq[$];
    clear_parser();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // sender idles lightly, receiver heavily
    send_idle = 9;
    recv_idle = 51;

    // NUL and space lead-in, single quote, brace with escaped close,
    // empty double quote, bare ended by comma, list closed by paren
    seq = '{8'h00, 8'h20, ChParOpen, ChSquote, 8'h61, ChSquote, ChBrOpen,
            ChBslash, ChBrClose, ChBrClose, ChDquote, ChDquote, 8'h78, ChComma,
            ChParClose};
    feed_seq(seq);
    // bad byte before the paren, all ones
    seq = '{8'hFF};
    feed_seq(seq);
    // bare argument closed by paren, then a byte after the end
    seq = '{ChParOpen, 8'h7A, ChParClose, 8'h71};
    feed_seq(seq);
    // buffer with no paren at all
    seq = '{8'h09};
    feed_seq(seq);
    // quoted argument still open at the end of the buffer
    seq = '{ChParOpen, ChDquote, 8'h61};
    feed_seq(seq);

    queue_random(240);
    wait_drain();

    // receiver idles lightly, sender heavily
    send_idle = 51;
    recv_idle = 9;
    queue_random(250);
    wait_drain();

    // no idling
    send_idle = 0;
    recv_idle = 0;
    queue_random(250);
    wait_drain();

    // let any stray result show up
    repeat (8) @(negedge clk_i);
    if (errors == 0) $display("TB_OK");
    else             $display("TB_ERROR");
    $finish;
  end

endmodule

>>> script_call_argument_splitter_top.f
sv/scas_pkg.sv
sv/script_call_argument_splitter_top.sv
sv/scas_checker.sv
test/tb_script_call_argument_splitter_top.sv
